>>> design/lir_pkg.sv
// Package for the linear interpolation resampler.
// Holds field widths, step limits, controller states and the command/status structs.
// No dependencies.
package lir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 18;
    localparam int PHASE_W  = 19;
    localparam int FRAC_W   = 16;
    localparam int CNT_W    = 3;

    localparam logic [STEP_W-1:0]  STEP_MIN  = 18'd32768;
    localparam logic [STEP_W-1:0]  STEP_MAX  = 18'd131072;
    localparam logic [STEP_W-1:0]  STEP_RST  = 18'd65536;
    localparam logic [PHASE_W-1:0] PHASE_ONE = 19'h10000;
    localparam logic [CNT_W-1:0]   MAX_OUT   = 3'd4;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK_A,
        ST_MUL,
        ST_EMIT_A,
        ST_CHECK_B,
        ST_EMIT_B
    } lir_state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic commit_prev;
        logic ph_sub;
        logic ph_add;
        logic mul_go;
        logic load_a;
        logic load_b;
        logic clear_all;
    } lir_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_prev;
        logic last;
        logic phase_lt_one;
        logic n_lt_max;
        logic out_free;
    } lir_status_t;

endpackage

>>> design/lir_ctrl.sv
// Controller state machine for the linear interpolation resampler.
// Sequences interpolation and tail-repeat outputs; depends on lir_pkg.
module lir_ctrl
    import lir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  lir_status_t status,
    output lir_cmd_t    cmd
);

    lir_state_t state_reg;
    lir_state_t state_next;
    logic       more;

    // another output due in the current loop
    assign more = status.phase_lt_one && status.n_lt_max;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.have_prev)
                begin
                    state_next = ST_CHECK_A;
                end
                else if (status.last)
                begin
                    state_next = ST_CHECK_B;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK_A:
            begin
                if (more)
                begin
                    state_next = ST_MUL;
                end
                else if (status.last)
                begin
                    state_next = ST_CHECK_B;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_EMIT_A;
            end
            ST_EMIT_A:
            begin
                if (status.out_free)
                begin
                    state_next = ST_CHECK_A;
                end
            end
            ST_CHECK_B:
            begin
                if (more)
                begin
                    state_next = ST_EMIT_B;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_B:
            begin
                if (status.out_free)
                begin
                    state_next = ST_CHECK_B;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            ST_START:
            begin
                cmd.commit_prev = !status.have_prev && !status.last;
            end
            ST_CHECK_A:
            begin
                if (!more)
                begin
                    cmd.ph_sub      = 1'b1;
                    cmd.commit_prev = !status.last;
                end
            end
            ST_MUL:
            begin
                cmd.mul_go = 1'b1;
            end
            ST_EMIT_A:
            begin
                cmd.load_a = status.out_free;
                cmd.ph_add = status.out_free;
            end
            ST_CHECK_B:
            begin
                cmd.clear_all = !more;
            end
            ST_EMIT_B:
            begin
                cmd.load_b = status.out_free;
                cmd.ph_add = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a new transaction is only taken from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |=> state_reg == ST_START)
        else $error("input latched outside idle hand-off");

    // the emit state always follows the multiply state
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_EMIT_A)
        else $error("emit did not follow multiply");

    // emit states never load an occupied output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_a || cmd.load_b) |-> status.out_free)
        else $error("output load while output register busy");

endmodule

>>> design/lir_datapath.sv
// Datapath for the linear interpolation resampler: step register, phase,
// sample history, multiply, round-half-even, saturation and output register.
// Depends on lir_pkg.
module lir_datapath
    import lir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pitch_step_we,
    input  logic [STEP_W-1:0]          pitch_step,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       clip_last,
    input  lir_cmd_t                   cmd,
    output lir_status_t                status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       run_end,
    output logic                       clip_end
);

    logic [STEP_W-1:0]          step_cfg_reg;
    logic [STEP_W-1:0]          step_sat;
    logic [STEP_W-1:0]          step_reg;
    logic signed [SAMPLE_W-1:0] cur_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic                       have_prev_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic [CNT_W-1:0]           n_reg;
    logic signed [33:0]         prod_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_run_end_reg;
    logic                       out_clip_end_reg;

    logic [PHASE_W:0]           ph_sum_wide;
    logic [PHASE_W-1:0]         ph_add_val;
    logic [PHASE_W-1:0]         ph_sub_val;
    logic [PHASE_W-1:0]         ph_add_sub;
    logic                       n_lt_last;
    logic                       more_a;
    logic                       more_b_after_a;
    logic                       more_b;

    logic signed [16:0]         diff;
    logic signed [16:0]         frac_s;
    logic signed [34:0]         num;
    logic signed [18:0]         q;
    logic [15:0]                rem;
    logic                       round_up;
    logic signed [19:0]         q_rnd;
    logic signed [SAMPLE_W-1:0] interp_val;

    // configuration register and clamp of the step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg <= STEP_RST;
        end
        else if (pitch_step_we)
        begin
            step_cfg_reg <= pitch_step;
        end
    end

    always_comb
    begin
        priority if (step_cfg_reg < STEP_MIN)
        begin
            step_sat = STEP_MIN;
        end
        else if (step_cfg_reg > STEP_MAX)
        begin
            step_sat = STEP_MAX;
        end
        else
        begin
            step_sat = step_cfg_reg;
        end
    end

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cur_reg  <= sample_in;
            last_reg <= clip_last;
            step_reg <= step_sat;
        end
    end

    // phase arithmetic and lookahead for the run and clip end flags
    assign ph_sum_wide    = {1'b0, phase_reg} + {2'b00, step_reg};
    assign ph_add_val     = ph_sum_wide[PHASE_W-1:0];
    assign ph_sub_val     = phase_reg - PHASE_ONE;
    assign ph_add_sub     = ph_add_val - PHASE_ONE;
    assign n_lt_last      = n_reg < (MAX_OUT - 3'd1);
    assign more_a         = (ph_add_val[PHASE_W-1:FRAC_W] == '0) && n_lt_last;
    assign more_b_after_a = last_reg && (ph_add_sub[PHASE_W-1:FRAC_W] == '0) && n_lt_last;
    assign more_b         = more_a;

    // history, phase and output count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            phase_reg     <= '0;
            n_reg         <= '0;
        end
        else
        begin
            if (cmd.clear_all)
            begin
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
            end
            else if (cmd.commit_prev)
            begin
                prev_reg      <= cur_reg;
                have_prev_reg <= 1'b1;
            end

            priority if (cmd.clear_all)
            begin
                phase_reg <= '0;
            end
            else if (cmd.ph_sub)
            begin
                phase_reg <= ph_sub_val;
            end
            else if (cmd.ph_add)
            begin
                phase_reg <= ph_add_val;
            end

            priority if (cmd.latch_in)
            begin
                n_reg <= '0;
            end
            else if (cmd.load_a || cmd.load_b)
            begin
                n_reg <= n_reg + 3'd1;
            end
        end
    end

    // fraction times difference, registered
    assign diff   = 17'(cur_reg) - 17'(prev_reg);
    assign frac_s = $signed({1'b0, phase_reg[FRAC_W-1:0]});

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            prod_reg <= 34'(diff) * 34'(frac_s);
        end
    end

    // add base, round half to even, saturate
    assign num      = $signed({{3{prev_reg[SAMPLE_W-1]}}, prev_reg, 16'h0000})
                    + 35'(prod_reg);
    assign q        = num[34:16];
    assign rem      = num[15:0];
    assign round_up = (rem > 16'h8000) || ((rem == 16'h8000) && q[0]);
    assign q_rnd    = 20'(q) + $signed({19'd0, round_up});

    always_comb
    begin
        priority if (q_rnd > 20'(SAMPLE_MAX))
        begin
            interp_val = SAMPLE_MAX;
        end
        else if (q_rnd < 20'(SAMPLE_MIN))
        begin
            interp_val = SAMPLE_MIN;
        end
        else
        begin
            interp_val = q_rnd[SAMPLE_W-1:0];
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_a || cmd.load_b)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            out_sample_reg   <= interp_val;
            out_run_end_reg  <= !more_a && !more_b_after_a;
            out_clip_end_reg <= last_reg && !more_a && !more_b_after_a;
        end
        else if (cmd.load_b)
        begin
            out_sample_reg   <= cur_reg;
            out_run_end_reg  <= !more_b;
            out_clip_end_reg <= !more_b;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign run_end    = out_run_end_reg;
    assign clip_end   = out_clip_end_reg;

    assign status.have_prev    = have_prev_reg;
    assign status.last         = last_reg;
    assign status.phase_lt_one = phase_reg[PHASE_W-1:FRAC_W] == '0;
    assign status.n_lt_max     = n_reg < MAX_OUT;
    assign status.out_free     = !out_valid_reg || out_ready;

    // never more than four outputs per transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_OUT)
        else $error("output count beyond four");

    // the clip end marks the last result of its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_clip_end_reg |-> out_run_end_reg)
        else $error("clip end without run end");

    // a load always presents a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_a || cmd.load_b) |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

>>> design/linear_interp_resampler_top.sv
// Each result comes from a check / multiply / emit loop around the single
// multiplier (tail repeats skip the multiply); a new input is accepted only
// when the controller is back in idle, after all outputs of the previous one
// are loaded, and output stalls hold the loop.
// Reset: rst_n asynchronous active low; clears history, phase and the output
// valid, and returns pitch_step to 65536. No clearing pass.
module linear_interp_resampler_top
    import lir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pitch_step_we,
    input  logic [STEP_W-1:0]          pitch_step,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       clip_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       run_end,
    output logic                       clip_end
);

    lir_cmd_t    cmd;
    lir_status_t status;

    // sequencer
    lir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    lir_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .pitch_step_we (pitch_step_we),
        .pitch_step    (pitch_step),
        .sample_in     (sample_in),
        .clip_last     (clip_last),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .run_end       (run_end),
        .clip_end      (clip_end)
    );

endmodule

>>> sim/tb_top.sv
// Testbench for linear_interp_resampler_top: random clips and pitch steps
// against a cycle-free resampling predictor. Depends on lir_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_top
    import lir_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_ITEMS = 170;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } clip_sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       run_end;
        logic                       clip_end;
    } resampled_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       pitch_step_we = 1'b0;
    logic [STEP_W-1:0]          pitch_step = STEP_RST;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       clip_last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       run_end;
    logic                       clip_end;

    clip_sample_t pending_samples[$];
    resampled_t   expected_outputs[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           steady_run = 1'b0;

    // predictor state
    logic [STEP_W-1:0]          step_reg = STEP_RST;
    logic signed [SAMPLE_W-1:0] hist_sample = '0;
    logic                       hist_valid = 1'b0;
    logic [PHASE_W-1:0]         phase_acc = '0;

    linear_interp_resampler_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pitch_step_we(pitch_step_we),
        .pitch_step   (pitch_step),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_in    (sample_in),
        .clip_last    (clip_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .run_end      (run_end),
        .clip_end     (clip_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // random idle cycle, none during the steady phase
    function automatic bit take_break();
        return !steady_run && ($urandom_range(99) < 36);
    endfunction

    // s0 + frac * (s1 - s0), round half to even, clamp to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] lerp_round(
        input logic signed [SAMPLE_W-1:0] s0,
        input logic signed [SAMPLE_W-1:0] s1,
        input logic [FRAC_W-1:0]          frac
    );
        longint num;
        longint q;
        longint r;
        num = longint'(s0) * 65536 + longint'(frac) * (longint'(s1) - longint'(s0));
        q = num >>> 16;
        r = num & 64'hFFFF;
        if (r > 64'h8000 || (r == 64'h8000 && q[0]))
            q = q + 1;
        if (q > longint'(SAMPLE_MAX))
            q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN))
            q = longint'(SAMPLE_MIN);
        return q[SAMPLE_W-1:0];
    endfunction

    // outputs caused by one accepted sample, appended to the expected queue
    task automatic resample_predict(
        input logic signed [SAMPLE_W-1:0] cur,
        input logic                       last
    );
        logic [PHASE_W-1:0] step_eff;
        resampled_t         outs [4];
        int                 n;
        begin
            n = 0;
            step_eff = {1'b0, step_reg};
            if (step_reg < STEP_MIN)
                step_eff = {1'b0, STEP_MIN};
            if (step_reg > STEP_MAX)
                step_eff = {1'b0, STEP_MAX};

            // positions between the previous and the current sample
            if (hist_valid)
            begin
                while (phase_acc < PHASE_ONE && n < MAX_OUT)
                begin
                    outs[n] = '{lerp_round(hist_sample, cur, phase_acc[FRAC_W-1:0]),
                                1'b0, 1'b0};
                    n = n + 1;
                    phase_acc = phase_acc + step_eff;
                end
                phase_acc = phase_acc - PHASE_ONE;
            end
            hist_sample = cur;
            hist_valid = 1'b1;

            // tail of the clip repeats the last sample, then history clears
            if (last)
            begin
                while (phase_acc < PHASE_ONE && n < MAX_OUT)
                begin
                    outs[n] = '{cur, 1'b0, 1'b0};
                    n = n + 1;
                    phase_acc = phase_acc + step_eff;
                end
                if (n > 0)
                    outs[n-1].clip_end = 1'b1;
                hist_sample = '0;
                hist_valid = 1'b0;
                phase_acc = '0;
            end
            if (n > 0)
                outs[n-1].run_end = 1'b1;
            for (int k = 0; k < n; k++)
                expected_outputs.push_back(outs[k]);
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_in <= '0;
            clip_last <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                resample_predict(sample_in, clip_last);
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() > 0 && !take_break())
                begin
                    clip_sample_t item;
                    item = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    sample_in <= item.sample;
                    clip_last <= item.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    $error("unexpected output transaction: sample_out %0d", sample_out);
                    mismatch_count++;
                end
                else
                begin
                    resampled_t want;
                    want = expected_outputs.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $error("sample_out: expected %0d, actual %0d", want.sample, sample_out);
                        mismatch_count++;
                    end
                    if (run_end !== want.run_end)
                    begin
                        $error("run_end: expected %0b, actual %0b", want.run_end, run_end);
                        mismatch_count++;
                    end
                    if (clip_end !== want.clip_end)
                    begin
                        $error("clip_end: expected %0b, actual %0b", want.clip_end, clip_end);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= !take_break();
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // block idle: inputs all taken, outputs all seen, then a settle pause
    task automatic wait_drained();
        begin
            @(posedge clk);
            while (pending_samples.size() > 0 || in_valid || expected_outputs.size() > 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        begin
            @(posedge clk);
            pitch_step_we <= 1'b1;
            pitch_step <= value;
            @(posedge clk);
            pitch_step_we <= 1'b0;
            step_reg = value;
        end
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        pending_samples.push_back('{value, last});
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int style);
        logic signed [SAMPLE_W-1:0] v;
        case (style)
            0: v = SAMPLE_W'($urandom);
            1: v = SAMPLE_W'($urandom_range(16) - 8);
            default:
            begin
                v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                if (v[SAMPLE_W-1])
                    v = v + SAMPLE_W'($urandom_range(4));
                else
                    v = v - SAMPLE_W'($urandom_range(4));
            end
        endcase
        return v;
    endfunction

    // one clip of random content, optionally left open
    task automatic queue_clip(input int len, input bit close);
        int style;
        begin
            style = $urandom_range(5);
            if (style > 2)
                style = 0;
            for (int i = 0; i < len; i++)
                push_sample(rand_sample(style), close && (i == len - 1));
        end
    endtask

    initial
    begin
        int random_items;
        int phase_target;
        int phase_items;
        int clip_len;
        int phase_no;

        random_items = 0;
        phase_no = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset step: single-sample clip, then full-scale swings
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(16'sd0, 1'b1);
        wait_drained();

        // half step: ties at half positions round to even
        write_step(STEP_MIN);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd2, 1'b0);
        push_sample(16'sd3, 1'b0);
        push_sample(-16'sd3, 1'b1);
        push_sample(-16'sd1, 1'b0);
        push_sample(-16'sd2, 1'b1);
        push_sample(SAMPLE_MIN, 1'b1);
        wait_drained();

        // double step: skipped samples
        write_step(STEP_MAX);
        push_sample(16'sd100, 1'b0);
        push_sample(16'sd200, 1'b0);
        push_sample(16'sd300, 1'b0);
        push_sample(16'sd400, 1'b0);
        push_sample(16'sd500, 1'b1);
        wait_drained();

        // step changes mid-clip, out-of-range steps clamp
        write_step(18'd98304);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        wait_drained();
        write_step({STEP_W{1'b1}});
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b1);
        wait_drained();
        write_step('0);
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd5, 1'b1);
        wait_drained();

        // random phases, each with its own step
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(3) == 0)
                write_step(STEP_W'($urandom));
            else
                write_step(STEP_W'($urandom_range(STEP_MAX, STEP_MIN)));
            steady_run = (phase_no == 2);
            phase_target = $urandom_range(40, 15);
            phase_items = 0;
            while (phase_items < phase_target)
            begin
                case ($urandom_range(9))
                    0: clip_len = 1;
                    1, 2: clip_len = $urandom_range(30, 13);
                    default: clip_len = $urandom_range(12, 2);
                endcase
                queue_clip(clip_len, 1'b1);
                phase_items += clip_len;
            end
            // sometimes leave a clip open across the step change
            if ($urandom_range(3) == 0)
            begin
                clip_len = $urandom_range(5, 1);
                queue_clip(clip_len, 1'b0);
                phase_items += clip_len;
            end
            wait_drained();
            random_items += phase_items;
            phase_no++;
        end

        steady_run = 1'b0;
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
design/lir_pkg.sv
design/lir_ctrl.sv
design/lir_datapath.sv
design/linear_interp_resampler_top.sv
sim/tb_top.sv
